>>> rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants of the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int unsigned FLOORS      = 4;
  localparam int unsigned FLOOR_W     = 2;
  localparam int unsigned HOLD_W      = 4;
  localparam int unsigned ELAPSED_W   = 5;
  localparam logic [HOLD_W-1:0]    HOLD_RESET  = 4'd3;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 5'd31;

  typedef logic [FLOORS-1:0]  fmap_t;
  typedef logic [FLOOR_W-1:0] floor_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MOVING = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DRIVE_STOP = 2'b00,
    DRIVE_UP   = 2'b01,
    DRIVE_DOWN = 2'b11
  } drive_e;

  // One result word.
  typedef struct packed {
    drive_e drive;
    logic   lamp;
    fmap_t  up;
    fmap_t  down;
    fmap_t  cab;
    mode_e  mode;
    floor_t floor_now;
  } res_t;

endpackage

>>> rtl/elevator_car_controller.sv
// ----------------------------------------------------------------------------
// elevator_car_controller
// One-car controller: latches buttons, tracks the floor, runs the door and
// picks the next destination, one poll word in, one status word out.
// ----------------------------------------------------------------------------
// A poll word updates the car state at the edge that accepts it, and its status
// word is registered at that edge into the output register, or into the skid
// register while the output register holds a word not yet taken. A new poll can
// be accepted every cycle while the skid register is empty; the two-entry output
// stage decouples the sides, and the input stalls only when both entries are full.
// Configure door_hold_ticks (reset 3) only while no poll is in flight.
module elevator_car_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ecc_pkg::HOLD_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         floor_seen_i,
  input  logic [ecc_pkg::FLOOR_W-1:0]  sensed_floor_i,
  input  logic [ecc_pkg::FLOORS-1:0]   hall_up_pressed_i,
  input  logic [ecc_pkg::FLOORS-1:0]   hall_down_pressed_i,
  input  logic [ecc_pkg::FLOORS-1:0]   cab_pressed_i,
  input  logic                         obstructed_i,
  input  logic                         second_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [1:0]            motor_drive_o,
  output logic                         door_lamp_o,
  output logic [ecc_pkg::FLOORS-1:0]   up_lights_o,
  output logic [ecc_pkg::FLOORS-1:0]   down_lights_o,
  output logic [ecc_pkg::FLOORS-1:0]   cab_lights_o,
  output logic [1:0]                   mode_o,
  output logic [ecc_pkg::FLOOR_W-1:0]  floor_now_o
);
  import ecc_pkg::*;

  logic [HOLD_W-1:0]    hold_q;
  mode_e                mode_q, mode_d;
  floor_t               floor_q, floor_d;
  floor_t               target_q, target_d;
  fmap_t                up_q, up_d;
  fmap_t                down_q, down_d;
  fmap_t                lock_q, lock_d;
  fmap_t                cab_q, cab_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  drive_e               drive_q, drive_d;
  logic                 lamp_q, lamp_d;

  res_t res_new;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic in_fire, out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // Poll update: next car state.
  always_comb begin
    logic found;
    fmap_t hall;
    up_d      = up_q | hall_up_pressed_i;
    down_d    = down_q | hall_down_pressed_i;
    cab_d     = cab_q | cab_pressed_i;
    lock_d    = lock_q;
    floor_d   = floor_q;
    target_d  = target_q;
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    drive_d   = drive_q;
    lamp_d    = lamp_q;
    found     = 1'b0;
    hall      = '0;

    if (floor_seen_i) begin
      floor_d = sensed_floor_i;
    end

    if (mode_d == MODE_MOVING && floor_d == target_d) begin
      drive_d   = DRIVE_STOP;
      lamp_d    = 1'b1;
      mode_d    = MODE_OPEN;
      elapsed_d = '0;
    end

    if (mode_d == MODE_OPEN) begin
      if (obstructed_i) begin
        elapsed_d = '0;
      end else begin
        if (second_tick_i && elapsed_d != ELAPSED_MAX) begin
          elapsed_d = elapsed_d + ELAPSED_W'(1);
        end
        if (elapsed_d > {1'b0, hold_q}) begin
          lamp_d = 1'b0;
          cab_d[target_d]  = 1'b0;
          up_d[target_d]   = 1'b0;
          down_d[target_d] = 1'b0;
          lock_d[target_d] = 1'b0;
          mode_d = MODE_IDLE;
        end
      end
    end

    if (mode_d != MODE_MOVING && mode_d != MODE_OPEN) begin
      mode_d = MODE_IDLE;
      // lowest cab request wins
      for (int i = 0; i < FLOORS; i++) begin
        if (!found && cab_d[i]) begin
          found    = 1'b1;
          target_d = floor_t'(i);
        end
      end
      // then the lowest unlocked hall call; drop a call at the current floor
      hall = (up_d | down_d) & ~lock_d;
      for (int i = 0; i < FLOORS; i++) begin
        if (!found && hall[i]) begin
          if (floor_t'(i) == floor_d) begin
            up_d[i]   = 1'b0;
            down_d[i] = 1'b0;
            lock_d[i] = 1'b0;
          end else begin
            found    = 1'b1;
            target_d = floor_t'(i);
          end
        end
      end
      if (found) begin
        lock_d[target_d] = 1'b1;
        mode_d = MODE_MOVING;
        if (target_d > floor_d) begin
          drive_d = DRIVE_UP;
        end else if (target_d < floor_d) begin
          drive_d = DRIVE_DOWN;
        end else begin
          drive_d = DRIVE_STOP;
        end
      end
    end
  end

  // Status word from the updated state.
  always_comb begin
    res_new.drive     = drive_d;
    res_new.lamp      = lamp_d;
    res_new.up        = up_d;
    res_new.down      = down_d;
    res_new.cab       = cab_d | lock_d;
    res_new.mode      = mode_d;
    res_new.floor_now = floor_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= HOLD_RESET;
      mode_q    <= MODE_IDLE;
      floor_q   <= '0;
      target_q  <= '0;
      up_q      <= '0;
      down_q    <= '0;
      lock_q    <= '0;
      cab_q     <= '0;
      elapsed_q <= '0;
      drive_q   <= DRIVE_STOP;
      lamp_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_data_i;
      end
      if (in_fire) begin
        mode_q    <= mode_d;
        floor_q   <= floor_d;
        target_q  <= target_d;
        up_q      <= up_d;
        down_q    <= down_d;
        lock_q    <= lock_d;
        cab_q     <= cab_d;
        elapsed_q <= elapsed_d;
        drive_q   <= drive_d;
        lamp_q    <= lamp_d;
      end
    end
  end

  // Output register with skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_new;
      end else begin
        out_q <= res_new;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign motor_drive_o = signed'(out_q.drive);
  assign door_lamp_o   = out_q.lamp;
  assign up_lights_o   = out_q.up;
  assign down_lights_o = out_q.down;
  assign cab_lights_o  = out_q.cab;
  assign mode_o        = out_q.mode;
  assign floor_now_o   = out_q.floor_now;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elevator car controller. A queue of poll words
// feeds a clocked driver; each accepted word is run through a car model in the
// bench and the status word it predicts is queued. A clocked monitor takes
// the status words and compares them field by field. The door hold time is
// changed between phases, and the phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ecc_pkg::*;

  typedef struct {
    logic   floor_seen;
    floor_t sensed;
    fmap_t  up;
    fmap_t  down;
    fmap_t  cab;
    logic   obstructed;
    logic   tick;
  } poll_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [HOLD_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic floor_seen_i = 1'b0;
  floor_t sensed_floor_i = '0;
  fmap_t hall_up_pressed_i = '0;
  fmap_t hall_down_pressed_i = '0;
  fmap_t cab_pressed_i = '0;
  logic obstructed_i = 1'b0;
  logic second_tick_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [1:0] motor_drive_o;
  logic door_lamp_o;
  fmap_t up_lights_o;
  fmap_t down_lights_o;
  fmap_t cab_lights_o;
  logic [1:0] mode_o;
  floor_t floor_now_o;

  always #2 clk_i = ~clk_i;

  elevator_car_controller u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .floor_seen_i       (floor_seen_i),
    .sensed_floor_i     (sensed_floor_i),
    .hall_up_pressed_i  (hall_up_pressed_i),
    .hall_down_pressed_i(hall_down_pressed_i),
    .cab_pressed_i      (cab_pressed_i),
    .obstructed_i       (obstructed_i),
    .second_tick_i      (second_tick_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .motor_drive_o      (motor_drive_o),
    .door_lamp_o        (door_lamp_o),
    .up_lights_o        (up_lights_o),
    .down_lights_o      (down_lights_o),
    .cab_lights_o       (cab_lights_o),
    .mode_o             (mode_o),
    .floor_now_o        (floor_now_o)
  );

  // Car model state, reset values.
  logic [HOLD_W-1:0]    door_hold = HOLD_RESET;
  mode_e                car_mode = MODE_IDLE;
  floor_t               car_floor = '0;
  floor_t               car_target = '0;
  fmap_t                up_req = '0;
  fmap_t                down_req = '0;
  fmap_t                cab_req = '0;
  fmap_t                locked = '0;
  logic [ELAPSED_W-1:0] door_count = '0;
  drive_e               car_drive = DRIVE_STOP;
  logic                 car_lamp = 1'b0;

  poll_t poll_q[$];
  res_t  status_q[$];
  poll_t cur_poll;
  int    errors = 0;
  int    results_seen = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic  hold_off = 1'b0;

  function automatic void head_for(floor_t dest);
    locked[dest] = 1'b1;
    car_target = dest;
    car_mode = MODE_MOVING;
    if (dest > car_floor) begin
      car_drive = DRIVE_UP;
    end else if (dest < car_floor) begin
      car_drive = DRIVE_DOWN;
    end else begin
      car_drive = DRIVE_STOP;
    end
  endfunction

  // Advance the car by one poll and queue the status word it produces.
  function automatic void advance_car(poll_t p);
    bit   found;
    res_t r;
    found = 1'b0;
    up_req |= p.up;
    down_req |= p.down;
    cab_req |= p.cab;
    if (p.floor_seen && p.sensed < FLOORS) car_floor = p.sensed;

    if (car_mode == MODE_MOVING && car_floor == car_target) begin
      car_drive = DRIVE_STOP;
      car_lamp = 1'b1;
      car_mode = MODE_OPEN;
      door_count = '0;
    end

    if (car_mode == MODE_OPEN) begin
      if (p.obstructed) begin
        door_count = '0;
      end else begin
        if (p.tick && door_count != ELAPSED_MAX) door_count++;
        if (door_count > {1'b0, door_hold}) begin
          car_lamp = 1'b0;
          cab_req[car_target] = 1'b0;
          up_req[car_target] = 1'b0;
          down_req[car_target] = 1'b0;
          locked[car_target] = 1'b0;
          car_mode = MODE_IDLE;
        end
      end
    end

    if (car_mode == MODE_IDLE) begin
      for (int i = 0; i < FLOORS; i++) begin
        if (!found && cab_req[i]) begin
          head_for(floor_t'(i));
          found = 1'b1;
        end
      end
      // Drop hall calls at the current floor, serve the lowest other one.
      for (int i = 0; i < FLOORS; i++) begin
        if (!found && (up_req[i] || down_req[i]) && !locked[i]) begin
          if (floor_t'(i) == car_floor) begin
            up_req[i] = 1'b0;
            down_req[i] = 1'b0;
            locked[i] = 1'b0;
          end else begin
            head_for(floor_t'(i));
            found = 1'b1;
          end
        end
      end
    end

    r.drive = car_drive;
    r.lamp = car_lamp;
    r.up = up_req;
    r.down = down_req;
    r.cab = cab_req | locked;
    r.mode = car_mode;
    r.floor_now = car_floor;
    status_q.push_back(r);
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      note_failure($sformatf("word %0d %s: expected %0h, got %0h",
                             results_seen, name, want, got));
    end
  endfunction

  // Driver: hold a stalled word, otherwise offer the next one after a random gap.
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        advance_car(cur_poll);
        offer = 1'b0;
      end
      if (!offer && poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_poll = poll_q.pop_front();
        offer = 1'b1;
        floor_seen_i <= cur_poll.floor_seen;
        sensed_floor_i <= cur_poll.sensed;
        hall_up_pressed_i <= cur_poll.up;
        hall_down_pressed_i <= cur_poll.down;
        cab_pressed_i <= cur_poll.cab;
        obstructed_i <= cur_poll.obstructed;
        second_tick_i <= cur_poll.tick;
      end
      in_valid_i <= offer;
    end
  end

  // Monitor: compare each taken status word with the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          note_failure($sformatf("word %0d arrived with no poll pending", results_seen));
        end else begin
          want = status_q.pop_front();
          check_field("motor_drive", 4'(want.drive), 4'($unsigned(motor_drive_o)));
          check_field("door_lamp", 4'(want.lamp), 4'(door_lamp_o));
          check_field("up_lights", want.up, up_lights_o);
          check_field("down_lights", want.down, down_lights_o);
          check_field("cab_lights", want.cab, cab_lights_o);
          check_field("mode", 4'(want.mode), 4'(mode_o));
          check_field("floor_now", 4'(want.floor_now), 4'(floor_now_o));
        end
        results_seen++;
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic fmap_t sparse_map();
    if ($urandom_range(99) < 15) return fmap_t'($urandom_range(15));
    return '0;
  endfunction

  function automatic poll_t rand_poll();
    poll_t p;
    if ($urandom_range(99) < 85) begin
      p.floor_seen = ($urandom_range(3) != 0);
      p.sensed = floor_t'($urandom_range(FLOORS - 1));
      p.up = sparse_map();
      p.down = sparse_map();
      p.cab = sparse_map();
      p.obstructed = ($urandom_range(99) < 8);
      p.tick = ($urandom_range(99) < 60);
    end else begin
      p.floor_seen = 1'($urandom_range(1));
      p.sensed = floor_t'($urandom_range(3));
      p.up = fmap_t'($urandom_range(15));
      p.down = fmap_t'($urandom_range(15));
      p.cab = fmap_t'($urandom_range(15));
      p.obstructed = 1'($urandom_range(1));
      p.tick = 1'($urandom_range(1));
    end
    return p;
  endfunction

  task automatic add_poll(logic seen, floor_t fl, fmap_t up, fmap_t down, fmap_t cab,
                          logic obs, logic tick);
    poll_t p;
    p.floor_seen = seen;
    p.sensed = fl;
    p.up = up;
    p.down = down;
    p.cab = cab;
    p.obstructed = obs;
    p.tick = tick;
    poll_q.push_back(p);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (poll_q.size() != 0 || in_valid_i || status_q.size() != 0);
  endtask

  task automatic run_phase(logic [HOLD_W-1:0] hold, int send_pct, int recv_pct,
                           int count, bit squeeze);
    drain();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    door_hold = hold;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    // Stall the output for a long stretch so the block backs up.
    if (squeeze) begin
      fork
        begin
          repeat (20) @(negedge clk_i);
          hold_off = 1'b1;
          repeat (80) @(negedge clk_i);
          hold_off = 1'b0;
        end
      join_none
    end
    repeat (count) poll_q.push_back(rand_poll());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed polls at the reset hold time of three seconds.
    add_poll(0, 0, 4'h0, 4'h0, 4'h0, 0, 0);   // nothing to serve
    add_poll(0, 0, 4'h0, 4'h0, 4'h1, 0, 0);   // cab call at the current floor
    add_poll(0, 0, 4'h0, 4'h0, 4'h0, 0, 1);   // opens, tick counted on arrival
    add_poll(0, 0, 4'h0, 4'h0, 4'h0, 1, 1);   // obstruction restarts the count
    repeat (4) add_poll(0, 0, 4'h0, 4'h0, 4'h0, 0, 1);
    add_poll(1, 0, 4'h1, 4'h4, 4'h0, 0, 0);   // hall call here is dropped
    add_poll(1, 1, 4'h0, 4'h0, 4'h0, 0, 1);   // passing a floor
    add_poll(1, 2, 4'h0, 4'h0, 4'h0, 0, 1);   // arrival
    add_poll(1, 2, 4'hF, 4'hF, 4'hF, 0, 0);
    repeat (3) add_poll(1, 2, 4'h0, 4'h0, 4'h0, 0, 1);
    add_poll(1, 3, 4'h0, 4'h0, 4'h0, 0, 0);
    add_poll(1, 0, 4'h0, 4'h0, 4'h0, 0, 1);
    repeat (5) add_poll(0, 3, 4'h0, 4'h0, 4'h0, 0, 1);

    run_phase(4'd0, 0, 0, 350, 1'b1);
    run_phase(4'd15, 53, 0, 350, 1'b0);
    run_phase(4'd1, 0, 53, 350, 1'b0);
    run_phase(HOLD_W'($urandom_range(14, 2)), 26, 26, 350, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && status_q.size() == 0) begin
      $display("elevator_car_controller test passed");
    end else begin
      $display("elevator_car_controller test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("elevator_car_controller test failed");
    $finish;
  end

endmodule
